/* rtl/tcdr_pkg.sv */
// ----------------------------------------------------------------------------
// tcdr_pkg
// Types, constants and helper functions shared by the setpoint ramp blocks.
// ----------------------------------------------------------------------------
package tcdr_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int CHANNELS_DEF  = 3;

   localparam int NUM_SETS   = 3;
   localparam int TGT_W      = 17;
   localparam int DUR_W      = 13;
   localparam int DUR_LSB    = 51;
   localparam int SPM_W      = 8;
   localparam int STEPS_W    = DUR_W + SPM_W;
   localparam int CODE_W     = 16;
   localparam int CHN_W      = 2;
   localparam int SPI_W      = 24;
   localparam int REG_W      = 64;
   localparam int ADDR_W     = 5;

   localparam logic [CODE_W-1:0] MAG_MAX = 16'hFFFF;

   localparam logic [REG_W-1:0] SET0_RESET = 64'd2251799813685248;
   localparam logic [REG_W-1:0] SET1_RESET = 64'd2289338114246793;
   localparam logic [REG_W-1:0] SET2_RESET = 64'd4466078506809207;
   localparam logic [SPM_W-1:0] SPM_RESET  = 8'd58;

   // register indexes (paddr[4:3])
   localparam logic [1:0] REG_SET0 = 2'd0;
   localparam logic [1:0] REG_SET1 = 2'd1;
   localparam logic [1:0] REG_SET2 = 2'd2;
   localparam logic [1:0] REG_SPM  = 2'd3;

   // opcodes
   localparam logic [1:0] OP_TRIGGER = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_NONE    = 2'd3;

   // setpoint set codes
   localparam logic [1:0] SET_0    = 2'd0;
   localparam logic [1:0] SET_1    = 2'd1;
   localparam logic [1:0] SET_2    = 2'd2;
   localparam logic [1:0] SET_NONE = 2'd3;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_TRIGGER,
      CMD_TICK,
      CMD_RELEASE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   set;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIV_START,
      BK_DIV_WAIT,
      BK_EMIT
   } bk_state_type;

   typedef logic [NUM_SETS-1:0][REG_W-1:0] set_regs_type;

   function automatic logic [REG_W-1:0] set_word(input set_regs_type regs,
                                                 input logic [1:0] s);
      logic [REG_W-1:0] w;
      case (s)
         SET_0:   w = regs[0];
         SET_1:   w = regs[1];
         SET_2:   w = regs[2];
         default: w = '0;
      endcase
      return w;
   endfunction

   // signed 17-bit target of one channel; channels beyond the packing read zero
   function automatic logic [TGT_W-1:0] tgt_raw(input logic [REG_W-1:0] w,
                                                input logic [CHN_W-1:0] ch);
      logic [TGT_W-1:0] t;
      case (ch)
         2'd0:    t = w[16:0];
         2'd1:    t = w[33:17];
         2'd2:    t = w[50:34];
         default: t = '0;
      endcase
      return t;
   endfunction

endpackage

/* rtl/tcdr_front.sv */
// ----------------------------------------------------------------------------
// tcdr_front
// Accepts request items, decodes opcode and select lines, queues commands.
// ----------------------------------------------------------------------------
module tcdr_front
   import tcdr_pkg::*;
(
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic       req_sel_line_a,
   input  logic       req_sel_line_b,
   output logic       q_push,
   output cmd_type    q_data,
   input  logic       q_full
);

   logic keep;
   logic accept;

   assign req_ready = ~q_full;
   assign accept    = req_valid & req_ready;

   always_comb begin
      keep        = 1'b0;
      q_data.kind = CMD_TICK;
      q_data.set  = SET_NONE;
      unique case (req_opcode)
         OP_TRIGGER: begin
            q_data.kind = CMD_TRIGGER;
            keep        = ~(req_sel_line_a & req_sel_line_b);
            if (req_sel_line_a) begin
               q_data.set = SET_1;
            end else if (req_sel_line_b) begin
               q_data.set = SET_2;
            end else begin
               q_data.set = SET_0;
            end
         end
         OP_TICK: begin
            q_data.kind = CMD_TICK;
            keep        = 1'b1;
         end
         OP_RELEASE: begin
            q_data.kind = CMD_RELEASE;
            keep        = 1'b1;
         end
         OP_NONE: begin
            keep = 1'b0;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // drop items that have no effect
   assign q_push = accept & keep;

endmodule

/* rtl/tcdr_queue.sv */
// ----------------------------------------------------------------------------
// tcdr_queue
// Short command queue between the decoder and the ramp engine.
// ----------------------------------------------------------------------------
module tcdr_queue
   import tcdr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_data
);

   cmd_type              entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff,  count_in;
   logic                 do_push, do_pop;

   assign full      = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !full)
      else $error("command queue overflow");

endmodule

/* rtl/tcdr_div.sv */
// ----------------------------------------------------------------------------
// tcdr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tcdr_div #(
   parameter int DVD_W = 33,
   parameter int DVS_W = 21
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] q_ff, q_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   rem_shift;
   logic [DVS_W:0]   rem_diff;
   logic             fits;

   assign rem_shift = {rem_ff, q_ff[DVD_W-1]};
   assign rem_diff  = rem_shift - {1'b0, dvs_ff};
   assign fits      = (rem_shift >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         q_in    = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         q_in   = {q_ff[DVD_W-2:0], fits};
         rem_in = fits ? rem_diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

/* rtl/tcdr_back.sv */
// ----------------------------------------------------------------------------
// tcdr_back
// Ramp engine: starts ramps, advances positions on ticks, emits DAC writes.
// ----------------------------------------------------------------------------
module tcdr_back
   import tcdr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int CHANNELS  = CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  set_regs_type      set_regs,
   input  logic [SPM_W-1:0]  steps_per_ms,
   input  logic              cmd_valid,
   input  cmd_type           cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHN_W-1:0]  rsp_channel,
   output logic [CODE_W-1:0] rsp_magnitude_code,
   output logic              rsp_positive,
   output logic [SPI_W-1:0]  rsp_spi_word,
   output logic              rsp_last
);

   localparam int POS_W = TGT_W + FRAC_BITS;
   localparam int MAG_W = POS_W;
   localparam int INC_W = POS_W + 1;
   localparam int CI_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CI_W-1:0] CH_LAST = CI_W'(CHANNELS - 1);
   localparam logic [POS_W:0]  HALF    = (POS_W + 1)'(1) << (FRAC_BITS - 1);

   bk_state_type         state_ff, state_in;
   logic signed [POS_W-1:0] pos_ff [CHANNELS];
   logic signed [POS_W-1:0] pos_in [CHANNELS];
   logic signed [INC_W-1:0] inc_ff [CHANNELS];
   logic signed [INC_W-1:0] inc_in [CHANNELS];
   logic [STEPS_W-1:0]   steps_left_ff, steps_left_in;
   logic                 busy_ff, busy_in;
   logic [1:0]           target_set_ff, target_set_in;
   logic [1:0]           last_set_ff, last_set_in;
   logic [CI_W-1:0]      ch_ff, ch_in;
   logic                 neg_ff, neg_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CHN_W-1:0]     rsp_channel_ff, rsp_channel_in;
   logic [CODE_W-1:0]    rsp_code_ff, rsp_code_in;
   logic                 rsp_positive_ff, rsp_positive_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 div_start;
   logic [MAG_W-1:0]     div_dividend;
   logic                 div_done;
   logic [MAG_W-1:0]     div_quot;

   logic [REG_W-1:0]     trig_word;
   logic [DUR_W-1:0]     dur;
   logic [STEPS_W-1:0]   prod;
   logic [STEPS_W-1:0]   nsteps;
   logic [STEPS_W-1:0]   steps_dec;
   logic [REG_W-1:0]     ramp_word;
   logic signed [POS_W-1:0] tgt_cur;
   logic signed [INC_W-1:0] delta;
   logic signed [POS_W-1:0] pos_cur;
   logic [POS_W-1:0]     abs_p;
   logic [POS_W:0]       rounded;
   logic [POS_W-FRAC_BITS:0] code_full;
   logic [CODE_W-1:0]    code_sat;

   tcdr_div #(
      .DVD_W (MAG_W),
      .DVS_W (STEPS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (steps_left_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // step count for a trigger
   assign trig_word = set_word(set_regs, cmd.set);
   assign dur       = (trig_word[DUR_LSB +: DUR_W] == '0) ? DUR_W'(1)
                                                          : trig_word[DUR_LSB +: DUR_W];
   assign prod      = STEPS_W'(dur) * STEPS_W'(steps_per_ms);
   assign nsteps    = (prod == '0) ? STEPS_W'(1) : prod;
   assign steps_dec = steps_left_ff - 1'b1;

   // per-channel delta for the division in progress
   assign ramp_word = set_word(set_regs, target_set_ff);
   assign tgt_cur   = {tgt_raw(ramp_word, CHN_W'(ch_ff)), {FRAC_BITS{1'b0}}};
   assign pos_cur   = pos_ff[ch_ff];
   assign delta     = INC_W'(tgt_cur) - INC_W'(pos_cur);
   assign div_dividend = delta[INC_W-1] ? MAG_W'(-delta) : MAG_W'(delta);

   // magnitude code of the channel being emitted, half away from zero
   assign abs_p     = pos_cur[POS_W-1] ? POS_W'(-pos_cur) : POS_W'(pos_cur);
   assign rounded   = {1'b0, abs_p} + HALF;
   assign code_full = rounded[POS_W:FRAC_BITS];
   assign code_sat  = (code_full > (POS_W - FRAC_BITS + 1)'(MAG_MAX)) ? MAG_MAX
                                                                   : code_full[CODE_W-1:0];

   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      inc_in          = inc_ff;
      steps_left_in   = steps_left_ff;
      busy_in         = busy_ff;
      target_set_in   = target_set_ff;
      last_set_in     = last_set_ff;
      ch_in           = ch_ff;
      neg_in          = neg_ff;
      cmd_pop         = 1'b0;
      div_start       = 1'b0;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_channel_in  = rsp_channel_ff;
      rsp_code_in     = rsp_code_ff;
      rsp_positive_in = rsp_positive_ff;
      rsp_last_in     = rsp_last_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.kind)
                  CMD_RELEASE: begin
                     last_set_in = SET_NONE;
                  end
                  CMD_TRIGGER: begin
                     if (!busy_ff && cmd.set != last_set_ff) begin
                        steps_left_in = nsteps;
                        target_set_in = cmd.set;
                        busy_in       = 1'b1;
                        ch_in         = '0;
                        state_in      = BK_DIV_START;
                     end
                  end
                  CMD_TICK: begin
                     if (busy_ff) begin
                        steps_left_in = steps_dec;
                        if (steps_dec == '0) begin
                           // final step: snap to the target as configured now
                           for (int c = 0; c < CHANNELS; c++) begin
                              pos_in[c] = {tgt_raw(ramp_word, CHN_W'(c)),
                                           {FRAC_BITS{1'b0}}};
                           end
                           busy_in     = 1'b0;
                           last_set_in = target_set_ff;
                        end else begin
                           for (int c = 0; c < CHANNELS; c++) begin
                              pos_in[c] = POS_W'(INC_W'(pos_ff[c]) + inc_ff[c]);
                           end
                        end
                        ch_in    = '0;
                        state_in = BK_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_DIV_START: begin
            div_start = 1'b1;
            neg_in    = delta[INC_W-1];
            state_in  = BK_DIV_WAIT;
         end
         BK_DIV_WAIT: begin
            if (div_done) begin
               inc_in[ch_ff] = neg_ff ? -INC_W'(div_quot) : INC_W'(div_quot);
               if (ch_ff == CH_LAST) begin
                  state_in = BK_IDLE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = BK_DIV_START;
               end
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_channel_in  = CHN_W'(ch_ff);
               rsp_code_in     = code_sat;
               rsp_positive_in = ~pos_cur[POS_W-1];
               rsp_last_in     = (ch_ff == CH_LAST);
               if (ch_ff == CH_LAST) begin
                  state_in = BK_IDLE;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         steps_left_ff <= '0;
         busy_ff       <= 1'b0;
         target_set_ff <= SET_NONE;
         last_set_ff   <= SET_NONE;
         ch_ff         <= '0;
         neg_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            pos_ff[c] <= '0;
            inc_ff[c] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         steps_left_ff <= steps_left_in;
         busy_ff       <= busy_in;
         target_set_ff <= target_set_in;
         last_set_ff   <= last_set_in;
         ch_ff         <= ch_in;
         neg_ff        <= neg_in;
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
         inc_ff        <= inc_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_channel_ff  <= rsp_channel_in;
      rsp_code_ff     <= rsp_code_in;
      rsp_positive_ff <= rsp_positive_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel        = rsp_channel_ff;
   assign rsp_magnitude_code = rsp_code_ff;
   assign rsp_positive       = rsp_positive_ff;
   assign rsp_spi_word       = {5'b0, rsp_channel_ff, 1'b0, rsp_code_ff};
   assign rsp_last           = rsp_last_ff;

   a_busy_steps: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> steps_left_ff != '0)
      else $error("ramp running with no steps left");

   a_busy_set: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> target_set_ff != SET_NONE)
      else $error("ramp running without a target set");

   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIV_WAIT) |-> busy_ff)
      else $error("increment division outside a ramp");

endmodule

/* rtl/triggered_three_channel_dac_ramp.sv */
// ----------------------------------------------------------------------------
// triggered_three_channel_dac_ramp
// Triggered linear setpoint ramp for coil DAC channels, with APB registers.
// ----------------------------------------------------------------------------
// A step tick goes through the command queue and the EMIT state to registered
//   outputs, one DAC write per cycle unless rsp_ready stalls, CHANNELS in all.
// A starting trigger occupies the engine while the one-bit-per-cycle increment
//   divider works out the increment of each channel in turn.
// A two-entry command queue lets items be accepted while the engine works.
// Reset (synchronous, active high) restores register defaults, zeroes positions.
module triggered_three_channel_dac_ramp
   import tcdr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF,
   parameter int CHANNELS  = CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_opcode,
   input  logic              req_sel_line_a,
   input  logic              req_sel_line_b,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHN_W-1:0]  rsp_channel,
   output logic [CODE_W-1:0] rsp_magnitude_code,
   output logic              rsp_positive,
   output logic [SPI_W-1:0]  rsp_spi_word,
   output logic              rsp_last,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [REG_W-1:0]  csr_pwdata,
   output logic [REG_W-1:0]  csr_prdata,
   output logic              csr_pready
);

   set_regs_type      set_regs_ff;
   logic [SPM_W-1:0]  spm_ff;
   logic              csr_wr;
   logic [1:0]        csr_idx;

   logic              q_push;
   cmd_type           q_push_data;
   logic              q_full;
   logic              q_pop;
   logic              q_valid;
   cmd_type           q_data;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:3];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         set_regs_ff[0] <= SET0_RESET;
         set_regs_ff[1] <= SET1_RESET;
         set_regs_ff[2] <= SET2_RESET;
         spm_ff         <= SPM_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SET0: set_regs_ff[0] <= csr_pwdata;
            REG_SET1: set_regs_ff[1] <= csr_pwdata;
            REG_SET2: set_regs_ff[2] <= csr_pwdata;
            REG_SPM:  spm_ff         <= csr_pwdata[SPM_W-1:0];
            default:  spm_ff         <= spm_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SET0: csr_prdata = set_regs_ff[0];
         REG_SET1: csr_prdata = set_regs_ff[1];
         REG_SET2: csr_prdata = set_regs_ff[2];
         REG_SPM:  csr_prdata = {{(REG_W - SPM_W){1'b0}}, spm_ff};
         default:  csr_prdata = '0;
      endcase
   end

   tcdr_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_sel_line_a (req_sel_line_a),
      .req_sel_line_b (req_sel_line_b),
      .q_push         (q_push),
      .q_data         (q_push_data),
      .q_full         (q_full)
   );

   tcdr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   tcdr_back #(
      .FRAC_BITS (FRAC_BITS),
      .CHANNELS  (CHANNELS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .set_regs           (set_regs_ff),
      .steps_per_ms       (spm_ff),
      .cmd_valid          (q_valid),
      .cmd                (q_data),
      .cmd_pop            (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel        (rsp_channel),
      .rsp_magnitude_code (rsp_magnitude_code),
      .rsp_positive       (rsp_positive),
      .rsp_spi_word       (rsp_spi_word),
      .rsp_last           (rsp_last)
   );

endmodule
